// ===== hdl/isb_pkg.sv =====
// ----------------------------------------------------------------------------
// isb_pkg: shared types and codes for the indexed sequence buffer
// Command and status codes, plus the input and result beat layouts.
// ----------------------------------------------------------------------------
package isb_pkg;

	typedef enum logic [2:0] {
		CMD_QUERY     = 3'd0,
		CMD_INS_FRONT = 3'd1,
		CMD_INS_REAR  = 3'd2,
		CMD_INS_AT    = 3'd3,
		CMD_DEL_FRONT = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_CLEAR     = 3'd6
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_code_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [4:0]         position;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] front_value;
		logic [4:0]         count;
		logic               is_empty;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

// ===== hdl/isb_datapath.sv =====
// ----------------------------------------------------------------------------
// isb_datapath: entry cells, count and result register
// Each cell shifts, loads or holds from a compare with the target index.
// ----------------------------------------------------------------------------
module isb_datapath #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  isb_pkg::dp_cmd_t  dp_cmd,
	input  isb_pkg::in_item_t in_data,
	output isb_pkg::out_item_t out_data
);
	import isb_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	in_item_t              item_q;
	logic [CW-1:0]         count_q;
	logic [DATA_WIDTH-1:0] entries_q [CAPACITY];
	out_item_t             res_q;

	logic [DATA_WIDTH-1:0] entries_nx [CAPACITY];
	logic [CW-1:0]         count_nx;
	logic [PW-1:0]         pos_w;
	logic [PW-1:0]         cnt_w;
	logic [PW-1:0]         at_w;
	logic [PW-1:0]         cnt_nx_w;
	logic                  is_ins;
	logic                  is_del;
	logic                  do_ins;
	logic                  do_del;
	logic [1:0]            status;
	logic [63:0]           val64;
	logic [DATA_WIDTH-1:0] store_word;
	logic signed [DATA_WIDTH-1:0] front_word;
	logic [63:0]           front64;

	always_comb begin
		pos_w  = PW'(item_q.position);
		cnt_w  = PW'(count_q);
		val64  = 64'(item_q.value);
		store_word = val64[DATA_WIDTH-1:0];
		is_ins = 1'b0;
		is_del = 1'b0;
		at_w   = '0;
		status = ST_OK;
		count_nx = count_q;
		case (item_q.cmd)
			CMD_INS_FRONT: begin
				is_ins = 1'b1;
			end
			CMD_INS_REAR: begin
				is_ins = 1'b1;
				at_w   = cnt_w;
			end
			CMD_INS_AT: begin
				is_ins = 1'b1;
				at_w   = pos_w;
			end
			CMD_DEL_FRONT: begin
				is_del = 1'b1;
			end
			CMD_DEL_AT: begin
				is_del = 1'b1;
				at_w   = pos_w;
			end
			default: ;
		endcase

		if (is_ins) begin
			if (at_w > cnt_w)
				status = ST_RANGE;
			else if (cnt_w >= PW'(CAPACITY))
				status = ST_FULL;
		end else if (is_del) begin
			if (item_q.cmd == CMD_DEL_FRONT && count_q == '0)
				status = ST_EMPTY;
			else if (at_w >= cnt_w)
				status = ST_RANGE;
		end
		do_ins = is_ins && (status == ST_OK);
		do_del = is_del && (status == ST_OK);

		for (int i = 0; i < CAPACITY; i++)
			entries_nx[i] = entries_q[i];
		if (do_ins) begin
			// open a slot at the target index, move the tail back
			for (int i = 1; i < CAPACITY; i++)
				if (PW'(i) > at_w)
					entries_nx[i] = entries_q[i-1];
			for (int i = 0; i < CAPACITY; i++)
				if (PW'(i) == at_w)
					entries_nx[i] = store_word;
			count_nx = count_q + 1'b1;
		end else if (do_del) begin
			for (int i = 0; i < CAPACITY - 1; i++)
				if (PW'(i) >= at_w)
					entries_nx[i] = entries_q[i+1];
			count_nx = count_q - 1'b1;
		end else if (item_q.cmd == CMD_CLEAR) begin
			count_nx = '0;
		end

		cnt_nx_w   = PW'(count_nx);
		front_word = entries_nx[0];
		front64    = 64'(front_word);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_cmd.exec) begin
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load)
			item_q <= in_data;
		if (dp_cmd.exec) begin
			for (int i = 0; i < CAPACITY; i++)
				entries_q[i] <= entries_nx[i];
			res_q.status      <= status;
			res_q.front_value <= (count_nx == '0) ? '0 : front64[31:0];
			res_q.count       <= cnt_nx_w[4:0];
			res_q.is_empty    <= (count_nx == '0);
		end
	end

	assign out_data = res_q;

endmodule

// ===== hdl/isb_ctrl.sv =====
// ----------------------------------------------------------------------------
// isb_ctrl: sequencing for the indexed sequence buffer
// Captures one beat, executes it once the result register is free.
// ----------------------------------------------------------------------------
module isb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output isb_pkg::dp_cmd_t dp_cmd
);
	import isb_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free   = !out_valid_q || !out_stall;
	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign dp_cmd.load = (state_q == S_IDLE) && in_valid;
	assign dp_cmd.exec = (state_q == S_EXEC) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_valid_q && !out_stall)
						out_valid_q <= 1'b0;
					if (in_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					// hold until the result register can take a new beat
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_exec_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.exec |=> out_valid_q)
		else $error("result not flagged after execute");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.exec |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load |=> (state_q == S_EXEC))
		else $error("captured beat not executed");

endmodule

// ===== hdl/indexed_sequence_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_buffer_unit: ordered list with insert and delete at index
// Flow: the input beat is captured, then executed into the result register,
// which waits while a stalled result is held; no new beat is accepted until
// the current one has executed. The entry cells all update in the execute step.
// Reset: count cleared and outputs idle; entry contents undefined until written.
// ----------------------------------------------------------------------------
module indexed_sequence_buffer_unit #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  isb_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output isb_pkg::out_item_t out_data
);
	import isb_pkg::*;

	dp_cmd_t dp_cmd;

	isb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd)
	);

	isb_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.dp_cmd   (dp_cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule
